### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also runs during reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/att_pkg.sv
// ---------------------------------------------------------------------------
// att_pkg
// Shared constants, widths and types of the averaged threshold trigger.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package att_pkg;

    // Ring depth of the moving average
    localparam int RING_DEPTH = 8;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int SLOT_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W    = $clog2(RING_DEPTH + 1);
    localparam int SUM_W    = SAMPLE_W + CNT_W - 1;
    localparam int BIT_W    = $clog2(SUM_W);

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_EN = CFG_IDX_W'(1);
    localparam logic [SAMPLE_W-1:0]  THRESHOLD_RST = SAMPLE_W'(2048);

    // Command queue between front and back; depth is a power of two
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Input item modes
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_PASS,
        CMD_AVG
    } t_cmd;

    typedef struct packed {
        t_cmd                cmd;
        logic [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W-1:0] threshold;
    } t_cmd_item;

endpackage

`default_nettype wire

### hw/rtl/att_front.sv
// ---------------------------------------------------------------------------
// att_front
// Holds the configuration registers and classifies accepted words into
// commands for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module att_front (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_push,
    input  wire                              i_mode,
    input  wire [att_pkg::SAMPLE_W-1:0]      i_sample,
    input  wire                              i_q_full,
    output logic                             o_q_push,
    output att_pkg::t_cmd_item               o_q_item,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [att_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [att_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                             o_ring_clr
);

    logic [att_pkg::SAMPLE_W-1:0] r_threshold;
    logic                         r_filter_en;
    logic                         cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Register writes; a zero threshold is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= att_pkg::THRESHOLD_RST;
            r_filter_en <= 1'b0;
        end else if (cfg_we) begin
            if (i_cfg_index == att_pkg::REG_THRESHOLD &&
                i_cfg_data[att_pkg::SAMPLE_W-1:0] != '0) begin
                r_threshold <= i_cfg_data[att_pkg::SAMPLE_W-1:0];
            end
            if (i_cfg_index == att_pkg::REG_FILTER_EN) begin
                r_filter_en <= i_cfg_data[0];
            end
        end
    end

    // Disabling the filter empties the ring
    assign o_ring_clr = cfg_we && (i_cfg_index == att_pkg::REG_FILTER_EN) && !i_cfg_data[0];

    // Classify the incoming word
    always_comb begin
        o_q_push           = i_push && !i_q_full;
        o_q_item.sample    = i_sample;
        o_q_item.threshold = r_threshold;
        if (i_mode == att_pkg::MODE_CLEAR) begin
            o_q_item.cmd = att_pkg::CMD_CLEAR;
        end else if (r_filter_en) begin
            o_q_item.cmd = att_pkg::CMD_AVG;
        end else begin
            o_q_item.cmd = att_pkg::CMD_PASS;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/att_queue.sv
// ---------------------------------------------------------------------------
// att_queue
// Short command queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module att_queue (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  att_pkg::t_cmd_item i_item,
    output logic               o_full,
    input  wire                i_pop,
    output logic               o_empty,
    output att_pkg::t_cmd_item o_item
);

    att_pkg::t_cmd_item                r_entry [att_pkg::Q_DEPTH];
    logic [att_pkg::Q_PTR_W-1:0]       r_wr_ptr;
    logic [att_pkg::Q_PTR_W-1:0]       r_rd_ptr;
    logic [att_pkg::Q_CNT_W-1:0]       r_count;
    logic                              do_push;
    logic                              do_pop;

    assign o_full  = (r_count == att_pkg::Q_CNT_W'(att_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/att_back.sv
// ---------------------------------------------------------------------------
// att_back
// Sequencer that runs the moving average ring, a bit-serial divider by the
// fill count, the two-state detector and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module att_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_q_empty,
    input  att_pkg::t_cmd_item           i_q_item,
    output logic                         o_q_pop,
    input  wire                          i_ring_clr,
    output logic                         o_empty,
    input  wire                          i_pop,
    output logic [att_pkg::SAMPLE_W-1:0] o_filtered,
    output logic                         o_triggered,
    output logic [att_pkg::SAMPLE_W-1:0] o_report_value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_DETECT,
        S_EMIT
    } t_state;

    localparam int SW = att_pkg::SAMPLE_W;
    localparam int CW = att_pkg::CNT_W;
    localparam int UW = att_pkg::SUM_W;

    t_state                          r_state;
    logic [SW-1:0]                   r_sample;
    logic [SW-1:0]                   r_thresh;
    logic [SW-1:0]                   r_value;
    logic [SW-1:0]                   r_ring [att_pkg::RING_DEPTH];
    logic [SW-1:0]                   r_old;
    logic [att_pkg::SLOT_W-1:0]      r_slot;
    logic [CW-1:0]                   r_fill;
    logic [UW-1:0]                   r_sum;
    logic [UW-1:0]                   r_quo;
    logic [CW-1:0]                   r_rem;
    logic [att_pkg::BIT_W-1:0]       r_bit;
    logic                            r_trig;
    logic [SW-1:0]                   r_held;
    logic [SW-1:0]                   r_last;
    logic                            r_out_valid;
    logic [SW-1:0]                   r_out_filtered;
    logic                            r_out_trig;
    logic [SW-1:0]                   r_out_report;

    logic                            ring_full;
    logic                            ring_we;
    logic [UW-1:0]                   n_sum;
    logic [CW-1:0]                   n_fill;
    logic [att_pkg::SLOT_W-1:0]      n_slot;
    logic [CW:0]                     rem_sh;
    logic                            quo_bit;
    logic [CW-1:0]                   n_rem;
    logic [UW-1:0]                   n_quo;
    logic                            out_free;
    logic                            emit_go;

    assign ring_full = (r_fill == CW'(att_pkg::RING_DEPTH));
    assign ring_we   = (r_state == S_SUM);
    assign out_free  = !r_out_valid || i_pop;
    assign emit_go   = (r_state == S_EMIT) && out_free;
    assign o_q_pop   = (r_state == S_IDLE) && !i_q_empty;

    // Ring update: drop the oldest entry once full, add the new sample
    always_comb begin
        n_sum  = r_sum - (ring_full ? UW'(r_old) : '0) + UW'(r_sample);
        n_fill = ring_full ? r_fill : r_fill + 1'b1;
        n_slot = (r_slot == att_pkg::SLOT_W'(att_pkg::RING_DEPTH - 1)) ? '0 : r_slot + 1'b1;
    end

    // One restoring division step per cycle
    always_comb begin
        rem_sh  = {r_rem, r_quo[UW-1]};
        quo_bit = (rem_sh >= {1'b0, r_fill});
        n_rem   = quo_bit ? CW'(rem_sh - {1'b0, r_fill}) : rem_sh[CW-1:0];
        n_quo   = {r_quo[UW-2:0], quo_bit};
    end

    // Ring storage, read data registered
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_slot] <= r_sample;
        end
        r_old <= r_ring[r_slot];
    end

    // Sequencer, detector and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_trig      <= 1'b0;
            r_held      <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Load a new result word or drop the popped one
            r_out_valid <= emit_go || (r_out_valid && !i_pop);
            if (i_ring_clr) begin
                r_slot <= '0;
                r_fill <= '0;
                r_sum  <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_sample <= i_q_item.sample;
                        r_thresh <= i_q_item.threshold;
                        r_value  <= i_q_item.sample;
                        unique case (i_q_item.cmd)
                            att_pkg::CMD_CLEAR: begin
                                r_trig  <= 1'b0;
                                r_held  <= '0;
                                r_slot  <= '0;
                                r_fill  <= '0;
                                r_sum   <= '0;
                                r_state <= S_EMIT;
                            end
                            att_pkg::CMD_AVG: begin
                                r_state <= S_SUM;
                            end
                            default: begin
                                r_state <= S_DETECT;
                            end
                        endcase
                    end
                end
                S_SUM: begin
                    r_sum   <= n_sum;
                    r_fill  <= n_fill;
                    r_slot  <= n_slot;
                    r_quo   <= n_sum;
                    r_rem   <= '0;
                    r_bit   <= att_pkg::BIT_W'(UW - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_quo <= n_quo;
                    r_rem <= n_rem;
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == '0) begin
                        r_value <= n_quo[SW-1:0];
                        r_state <= S_DETECT;
                    end
                end
                S_DETECT: begin
                    r_last <= r_value;
                    if (!r_trig) begin
                        if (r_value > r_thresh) begin
                            r_trig <= 1'b1;
                            r_held <= r_value;
                        end
                    end else begin
                        r_held <= r_value;
                        if (r_value <= r_thresh) begin
                            r_trig <= 1'b0;
                        end
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_filtered <= r_last;
                        r_out_trig     <= r_trig;
                        r_out_report   <= r_held;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_filtered     = r_out_filtered;
    assign o_triggered    = r_out_trig;
    assign o_report_value = r_out_report;

endmodule

`default_nettype wire

### hw/rtl/averaged_threshold_trigger_unit.sv
// ---------------------------------------------------------------------------
// averaged_threshold_trigger_unit
// Moving-average threshold detector: front end with configuration and a
// command queue, back end with ring, serial divider and detector.
// ---------------------------------------------------------------------------
// Flow: an averaged sample runs through S_IDLE, S_SUM, S_DIV, S_DETECT and
//   S_EMIT; a raw sample skips S_SUM and S_DIV, a clear word goes to S_EMIT.
// A new command is taken only after S_EMIT, which waits for a free result
//   register; the serial divider by the fill count gives one bit per cycle.
// Reset: synchronous, active low; clears the queue, detector, ring count and sum.
//   Ring entries are not swept; the fill count masks stale entries.
`timescale 1ns / 1ps
`default_nettype none

module averaged_threshold_trigger_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_push,
    output logic                             o_full,
    input  wire                              i_mode,
    input  wire [att_pkg::SAMPLE_W-1:0]      i_sample,
    output logic                             o_empty,
    input  wire                              i_pop,
    output logic [att_pkg::SAMPLE_W-1:0]     o_filtered,
    output logic                             o_triggered,
    output logic [att_pkg::SAMPLE_W-1:0]     o_report_value,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [att_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [att_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    att_pkg::t_cmd_item wr_item;
    att_pkg::t_cmd_item rd_item;
    logic               q_push;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    logic               ring_clr;

    assign o_full = q_full;

    // Accept and classify words
    att_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_mode      (i_mode),
        .i_sample    (i_sample),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_item    (wr_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ring_clr  (ring_clr)
    );

    // Hold commands between the two sides
    att_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (wr_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (rd_item)
    );

    // Carry out commands
    att_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_item       (rd_item),
        .o_q_pop        (q_pop),
        .i_ring_clr     (ring_clr),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_filtered     (o_filtered),
        .o_triggered    (o_triggered),
        .o_report_value (o_report_value)
    );

endmodule

`default_nettype wire

### hw/rtl/att_checker.sv
// ---------------------------------------------------------------------------
// att_checker
// Port-level checks of the averaged threshold trigger, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module att_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              o_full,
    input wire                              o_empty,
    input wire                              i_pop,
    input wire [att_pkg::SAMPLE_W-1:0]      o_filtered,
    input wire                              o_triggered,
    input wire [att_pkg::SAMPLE_W-1:0]      o_report_value
);

    // Reset leaves no result waiting and the input open
    `ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, o_empty && !o_full)

    // A waiting result holds until popped
    `ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, !o_empty && !i_pop,
                 !o_empty && $stable(o_filtered) && $stable(o_triggered) && $stable(o_report_value))

    // While triggered the report follows the filtered value
    `ASSERT_IMPLIES(a_trig_report, i_clk, i_rst_n, !o_empty && o_triggered,
                    o_report_value == o_filtered)

endmodule

bind averaged_threshold_trigger_unit att_checker u_att_checker (.*);

`default_nettype wire

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the averaged threshold trigger unit: a queue-fed
// driver and a scoreboard predict every result word from a local model of
// the ring, the mean and the two-state detector, across several register
// settings, with random idle cycles on both sides and repeated long output holds.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import att_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int WORDS_PER_PHASE = 210;
    localparam int RANDOM_PHASES = 8;
    // Any index above the last register must be dropped by the block
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = '1;

    typedef struct packed {
        logic                mode;
        logic [SAMPLE_W-1:0] sample;
    } t_word;

    typedef struct packed {
        logic [SAMPLE_W-1:0] filtered;
        logic                triggered;
        logic [SAMPLE_W-1:0] report;
    } t_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_push = 1'b0;
    logic                  i_mode = MODE_SAMPLE;
    logic [SAMPLE_W-1:0]   i_sample = '0;
    logic                  i_pop = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_full;
    logic                  o_empty;
    logic [SAMPLE_W-1:0]   o_filtered;
    logic                  o_triggered;
    logic [SAMPLE_W-1:0]   o_report_value;
    logic                  o_cfg_ready;

    averaged_threshold_trigger_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_mode         (i_mode),
        .i_sample       (i_sample),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_filtered     (o_filtered),
        .o_triggered    (o_triggered),
        .o_report_value (o_report_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Local model of the block
    logic [SAMPLE_W-1:0] ring_val [RING_DEPTH];
    int                  wr_slot = 0;
    int                  fill_cnt = 0;
    int                  ring_total = 0;
    logic                trig_state = 1'b0;
    logic [SAMPLE_W-1:0] held_level = '0;
    logic [SAMPLE_W-1:0] last_level = '0;
    logic [SAMPLE_W-1:0] trip_level = THRESHOLD_RST;
    logic                avg_on = 1'b0;

    t_word   words_to_send [$];
    t_report results_due [$];
    logic    word_taken = 1'b0;
    logic    quiet_run = 1'b0;
    int      send_gap = 0;
    int      pop_gap = 0;
    int      hold_left = 0;
    int      next_hold_at = 150;
    int      n_cycles = 0;
    int      n_words_in = 0;
    int      n_clears = 0;
    int      n_results = 0;
    int      n_trips = 0;
    int      n_reg_writes = 0;
    int      n_mismatch = 0;

    function automatic void empty_ring();
        for (int k = 0; k < RING_DEPTH; k++) begin
            ring_val[k] = '0;
        end
        wr_slot = 0;
        fill_cnt = 0;
        ring_total = 0;
    endfunction

    // Advance the model by one word and return the result word it causes
    function automatic t_report trigger_next(input logic mode, input logic [SAMPLE_W-1:0] smp);
        t_report             r;
        logic [SAMPLE_W-1:0] v;
        if (mode == MODE_CLEAR) begin
            trig_state = 1'b0;
            held_level = '0;
            empty_ring();
        end else begin
            if (avg_on) begin
                ring_total = ring_total - int'(ring_val[wr_slot]) + int'(smp);
                ring_val[wr_slot] = smp;
                wr_slot = (wr_slot + 1 >= RING_DEPTH) ? 0 : wr_slot + 1;
                if (fill_cnt < RING_DEPTH) fill_cnt++;
                v = SAMPLE_W'(ring_total / fill_cnt);
            end else begin
                v = smp;
            end
            last_level = v;
            if (!trig_state) begin
                if (v > trip_level) begin
                    trig_state = 1'b1;
                    held_level = v;
                    n_trips++;
                end
            end else begin
                held_level = v;
                if (v <= trip_level) trig_state = 1'b0;
            end
        end
        r.filtered = last_level;
        r.triggered = trig_state;
        r.report = held_level;
        return r;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_THRESHOLD: begin
                // zero threshold is refused, old level kept
                if (val[SAMPLE_W-1:0] != '0) trip_level = val[SAMPLE_W-1:0];
            end
            REG_FILTER_EN: begin
                avg_on = val[0];
                if (!val[0]) empty_ring();
            end
            default: ;
        endcase
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_run || r < 70) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [SAMPLE_W-1:0] clamp_level(input int x);
        if (x < 0) return '0;
        if (x > 4095) return '1;
        return SAMPLE_W'(x);
    endfunction

    // Clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     n_cycles, results_due.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Drive input words: hold until taken, then pause or present the next
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_push && !word_taken)) begin
            if (i_push) void'(words_to_send.pop_front());
            if (send_gap > 0) begin
                send_gap--;
                i_push <= 1'b0;
            end else if (words_to_send.size() != 0) begin
                i_push <= 1'b1;
                i_mode <= words_to_send[0].mode;
                i_sample <= words_to_send[0].sample;
                send_gap = draw_gap();
            end else begin
                i_push <= 1'b0;
            end
        end
    end

    // Drive pop: random stalls plus a long hold now and then to back up the block
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else if (n_results >= next_hold_at) begin
                hold_left = HOLD_CYCLES;
                next_hold_at += 700;
                i_pop <= 1'b0;
            end else if (pop_gap > 0) begin
                pop_gap--;
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
                pop_gap = draw_gap();
            end
        end
    end

    // Check popped words first, then predict for the word taken at this edge
    always @(posedge i_clk) begin
        word_taken <= i_rst_n && i_push && !o_full;
        if (i_rst_n && i_pop && !o_empty) begin
            n_results++;
            if (results_due.size() == 0) begin
                n_mismatch++;
                $display("%0t: unexpected word filtered=%0d triggered=%0d report=%0d",
                         $time, o_filtered, o_triggered, o_report_value);
            end else begin
                if (o_filtered !== results_due[0].filtered) begin
                    n_mismatch++;
                    $display("%0t: filtered expected %0d actual %0d",
                             $time, results_due[0].filtered, o_filtered);
                end
                if (o_triggered !== results_due[0].triggered) begin
                    n_mismatch++;
                    $display("%0t: triggered expected %0d actual %0d",
                             $time, results_due[0].triggered, o_triggered);
                end
                if (o_report_value !== results_due[0].report) begin
                    n_mismatch++;
                    $display("%0t: report_value expected %0d actual %0d",
                             $time, results_due[0].report, o_report_value);
                end
                void'(results_due.pop_front());
            end
        end
        if (i_rst_n && i_push && !o_full) begin
            results_due.push_back(trigger_next(i_mode, i_sample));
            n_words_in++;
            if (i_mode == MODE_CLEAR) n_clears++;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, val);
        n_reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every queued word is taken and every result popped
    task automatic wait_idle();
        while (words_to_send.size() != 0 || i_push || results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_word(input logic mode, input logic [SAMPLE_W-1:0] smp);
        t_word w;
        w.mode = mode;
        w.sample = smp;
        words_to_send.push_back(w);
    endtask

    initial begin
        int                  run_left;
        int                  base;
        int                  pick;
        logic [SAMPLE_W-1:0] thr_pick;
        logic                en_pick;
        empty_ring();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults, pass-through: both extremes, equal and just above the level
        write_reg(REG_THRESHOLD, '0);
        write_reg(REG_SPARE, 12'h5A5);
        queue_word(MODE_SAMPLE, 12'd0);
        queue_word(MODE_SAMPLE, 12'd4095);
        queue_word(MODE_SAMPLE, 12'd2049);
        queue_word(MODE_SAMPLE, 12'd2048);
        queue_word(MODE_SAMPLE, 12'd100);
        queue_word(MODE_CLEAR, 12'd4095);
        queue_word(MODE_SAMPLE, 12'd2049);
        wait_idle();

        // Averaging: fill and wrap the ring, then clear it with a word
        write_reg(REG_FILTER_EN, 12'hFFF);
        for (int k = 0; k < RING_DEPTH + 1; k++) queue_word(MODE_SAMPLE, 12'd4095);
        queue_word(MODE_SAMPLE, 12'd0);
        queue_word(MODE_CLEAR, 12'd0);
        queue_word(MODE_SAMPLE, 12'd1);
        queue_word(MODE_SAMPLE, 12'd800);
        queue_word(MODE_SAMPLE, 12'd1200);
        wait_idle();

        // Disable empties the ring, enable keeps it
        write_reg(REG_FILTER_EN, 12'h000);
        write_reg(REG_FILTER_EN, 12'h001);
        queue_word(MODE_SAMPLE, 12'd600);
        queue_word(MODE_SAMPLE, 12'd3000);
        wait_idle();

        // Random phases: extreme settings first, then random ones
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin thr_pick = 12'd1;    en_pick = 1'b1; end
                1: begin thr_pick = 12'd4095; en_pick = 1'b0; end
                2: begin thr_pick = 12'd4095; en_pick = 1'b1; end
                3: begin thr_pick = 12'd1;    en_pick = 1'b0; end
                default: begin
                    thr_pick = SAMPLE_W'($urandom_range(1, 4095));
                    en_pick = 1'($urandom_range(0, 1));
                end
            endcase
            if ($urandom_range(0, 3) == 0) write_reg(REG_THRESHOLD, '0);
            write_reg(REG_THRESHOLD, thr_pick);
            write_reg(REG_FILTER_EN, {(CFG_DATA_W-1)'($urandom), en_pick});
            if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
            quiet_run = (p == 2 || p == 5);

            // Runs of samples around one level so the mean can cross the threshold
            run_left = 0;
            base = 0;
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                if (run_left == 0) begin
                    run_left = $urandom_range(1, 12);
                    pick = $urandom_range(0, 99);
                    if (pick < 45) base = int'(trip_level) + $urandom_range(0, 160) - 80;
                    else if (pick < 85) base = $urandom_range(0, 4095);
                    else base = ($urandom_range(0, 1) == 1) ? 4095 : 0;
                end
                run_left--;
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    queue_word(MODE_CLEAR, SAMPLE_W'($urandom));
                end else if (pick < 14) begin
                    queue_word(MODE_SAMPLE, SAMPLE_W'($urandom));
                end else begin
                    queue_word(MODE_SAMPLE,
                               clamp_level(base + $urandom_range(0, 32) - 16));
                end
            end
            wait_idle();
        end
        quiet_run = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("run covered %0d words (%0d clears), %0d results, %0d trigger entries",
                 n_words_in, n_clears, n_results, n_trips);
        $display("over %0d register writes, %0d results left unseen, %0d mismatches",
                 n_reg_writes, results_due.size(), n_mismatch);
        if (n_mismatch == 0 && results_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
